// File: hdl/palette_image_rle_decoder_assert.svh
// Assertion macros for the palette image span decoder.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PALETTE_IMAGE_RLE_DECODER_ASSERT_SVH
`define PALETTE_IMAGE_RLE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define PIRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PIRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PIRD_ASSERT(lbl, prop, msg)
`define PIRD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/pird_pkg.sv
// Shared types and constants of the palette image span decoder.
// No dependencies.
package pird_pkg;

  localparam int unsigned DimW   = 12;
  localparam int unsigned RunW   = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ProdW  = 2 * DimW;
  localparam int unsigned QuotW  = 7;
  localparam int unsigned PosW   = DimW + 1;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [ByteW-1:0] SkipBase   = 8'd128;
  localparam logic [ByteW-1:0] RepeatBase = 8'd192;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegMode   = 2'd2;

  typedef enum logic [1:0] {
    KIND_CONTROL = 2'd0,
    KIND_LITERAL = 2'd1,
    KIND_REPEAT  = 2'd2
  } pird_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PREP = 2'd1,
    ST_EMIT = 2'd2,
    ST_DIV  = 2'd3
  } pird_state_e;

  // effective image size and mode
  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            compressed;
  } pird_cfg_t;

  typedef struct packed {
    logic take;
    logic prep;
    logic emit;
    logic step;
  } pird_cmd_t;

  typedef struct packed {
    logic span;
    logic out_free;
    logic done;
    logic div_last;
  } pird_status_t;

endpackage

// File: hdl/palette_image_rle_decoder.sv
// Top level of the palette image span decoder.
// Depends on pird_pkg, pird_regs, pird_ctrl, pird_dp and the assertion header.
//
//  channel   signals                          direction  moves
//  config    psel/penable/pwrite/paddr/...    in/out     register request
//  byte in   in_valid_i/in_ready_o            in         data_byte_i
//  span out  out_valid_o/out_ready_i          out        span_x_o .. image_done_o
//
// A byte that yields no span leaves the input ready for the next one. A span byte
// goes through accept, position prep with the row multiply, emit and, unless the
// image ends there, 7 steps of the restoring divider wrapping the column by width.
// Emit waits while the previous span is still unclaimed in the output register.
// Reset puts the position at zero with a control byte expected; no clearing pass.
`include "palette_image_rle_decoder_assert.svh"

module palette_image_rle_decoder #(
  parameter int unsigned MAX_DIMENSION = 4095
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pird_pkg::AddrW-1:0] paddr,
  input  logic [pird_pkg::DataW-1:0] pwdata,
  output logic [pird_pkg::DataW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [pird_pkg::ByteW-1:0] data_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pird_pkg::DimW-1:0]  span_x_o,
  output logic [pird_pkg::DimW-1:0]  span_y_o,
  output logic [pird_pkg::RunW-1:0]  span_length_o,
  output logic [pird_pkg::ByteW-1:0] color_index_o,
  output logic                       transparent_o,
  output logic                       image_done_o
);
  import pird_pkg::*;

  pird_cfg_t    cfg;
  pird_cmd_t    cmd;
  pird_status_t status;

  pird_regs #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  pird_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pird_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .span_x_o     (span_x_o),
    .span_y_o     (span_y_o),
    .span_length_o(span_length_o),
    .color_index_o(color_index_o),
    .transparent_o(transparent_o),
    .image_done_o (image_done_o)
  );

  `PIRD_ASSERT(a_span_nonempty, !out_valid_o || (span_length_o != '0), "empty span")
  `PIRD_ASSERT(a_skip_no_color, !(out_valid_o && transparent_o) || (color_index_o == '0), "skip span has color")
  `PIRD_ASSERT_NEXT(a_quiet_byte, in_valid_i && in_ready_o && !status.span, in_ready_o, "stall after quiet byte")

endmodule

// File: hdl/pird_regs.sv
// Configuration registers behind the APB-style port, with size clamping.
// Depends on pird_pkg.
module pird_regs #(
  parameter int unsigned MAX_DIMENSION = 4095
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pird_pkg::AddrW-1:0] paddr,
  input  logic [pird_pkg::DataW-1:0] pwdata,
  output logic [pird_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output pird_pkg::pird_cfg_t        cfg_o
);
  import pird_pkg::*;

  localparam int unsigned CapInt = (MAX_DIMENSION > 4095) ? 4095 : MAX_DIMENSION;
  localparam logic [DimW-1:0] DimCap = DimW'(CapInt);

  logic [DimW-1:0] width_q, height_q;
  logic            mode_q;
  logic            wr_en;
  logic [1:0]      reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(1);
      height_q <= DimW'(1);
      mode_q   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegWidth:  width_q  <= pwdata[DimW-1:0];
        RegHeight: height_q <= pwdata[DimW-1:0];
        RegMode:   mode_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegWidth:  prdata = {{(DataW-DimW){1'b0}}, width_q};
      RegHeight: prdata = {{(DataW-DimW){1'b0}}, height_q};
      RegMode:   prdata = {{(DataW-1){1'b0}}, mode_q};
      default:   prdata = '0;
    endcase
  end

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = (v == '0) ? DimW'(1) : v;
    if (r > DimCap) r = DimCap;
    return r;
  endfunction

  assign cfg_o.width      = clamp_dim(width_q);
  assign cfg_o.height     = clamp_dim(height_q);
  assign cfg_o.compressed = mode_q;

endmodule

// File: hdl/pird_ctrl.sv
// Sequencer of the span decoder: accept, position prep, emit, wrap divide.
// Depends on pird_pkg.
module pird_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pird_pkg::pird_status_t status_i,
  output pird_pkg::pird_cmd_t    cmd_o
);
  import pird_pkg::*;

  pird_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (status_i.span) state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the previous span has left the output register
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.done ? ST_IDLE : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/pird_dp.sv
// Datapath: byte decode, raster position, span length and output register.
// Depends on pird_pkg.
module pird_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pird_pkg::pird_cfg_t        cfg_i,
  input  pird_pkg::pird_cmd_t        cmd_i,
  output pird_pkg::pird_status_t     status_o,
  input  logic [pird_pkg::ByteW-1:0] data_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pird_pkg::DimW-1:0]  span_x_o,
  output logic [pird_pkg::DimW-1:0]  span_y_o,
  output logic [pird_pkg::RunW-1:0]  span_length_o,
  output logic [pird_pkg::ByteW-1:0] color_index_o,
  output logic                       transparent_o,
  output logic                       image_done_o
);
  import pird_pkg::*;

  localparam int unsigned ShW = PosW + QuotW - 1;

  pird_kind_e       kind_q, kind_nx;
  logic [RunW-1:0]  count_q, count_nx;
  logic [DimW-1:0]  col_q, row_q;
  logic [RunW-1:0]  run_q, run_nx;
  logic [ByteW-1:0] color_q, color_nx;
  logic             transp_q, transp_nx;
  logic             span_nx;
  logic [ByteW-1:0] sub_skip, sub_rep, sub_one;

  logic [ProdW-1:0] prod_q;
  logic             oob;
  logic [DimW-1:0]  col_n, row_n, rows_below;
  logic [ProdW-1:0] remaining;
  logic [RunW-1:0]  len;
  logic             done;

  logic [PosW-1:0]  rem_q, rem_nx;
  logic [QuotW-1:0] quo_q, quo_nx;
  logic [2:0]       k_q;
  logic [ShW-1:0]   shifted;

  logic             out_valid_q;

  // ---- byte decode ----
  assign sub_skip = data_byte_i - SkipBase;
  assign sub_rep  = data_byte_i - RepeatBase;
  assign sub_one  = data_byte_i - 8'd1;

  always_comb begin
    kind_nx   = KIND_CONTROL;
    count_nx  = '0;
    span_nx   = 1'b0;
    run_nx    = RunW'(1);
    color_nx  = data_byte_i;
    transp_nx = 1'b0;
    unique case (kind_q)
      KIND_LITERAL: begin
        span_nx = 1'b1;
        if (count_q != '0) begin
          kind_nx  = KIND_LITERAL;
          count_nx = count_q - RunW'(1);
        end
      end
      KIND_REPEAT: begin
        run_nx  = count_q;
        span_nx = (count_q != '0);
      end
      default: begin
        if (cfg_i.compressed) begin
          if (data_byte_i > SkipBase) begin
            span_nx   = 1'b1;
            run_nx    = sub_skip[RunW-1:0];
            transp_nx = 1'b1;
          end else if (data_byte_i != '0) begin
            kind_nx  = KIND_LITERAL;
            count_nx = sub_one[RunW-1:0];
          end
        end else if (data_byte_i > RepeatBase) begin
          kind_nx  = KIND_REPEAT;
          count_nx = sub_rep[RunW-1:0];
        end else begin
          span_nx = 1'b1;
        end
      end
    endcase
  end

  // ---- position prep and span length ----
  assign oob        = (col_q >= cfg_i.width) || (row_q >= cfg_i.height);
  assign col_n      = oob ? '0 : col_q;
  assign row_n      = oob ? '0 : row_q;
  assign rows_below = cfg_i.height - DimW'(1) - row_n;

  assign remaining = prod_q + ProdW'(cfg_i.width - col_q);
  assign len       = (ProdW'(run_q) < remaining) ? run_q : remaining[RunW-1:0];
  assign done      = (ProdW'(len) == remaining);

  // ---- restoring divide of column + len by width, one quotient bit a step ----
  assign shifted = ShW'(cfg_i.width) << k_q;
  always_comb begin
    rem_nx = rem_q;
    quo_nx = quo_q;
    if (ShW'(rem_q) >= shifted) begin
      rem_nx     = rem_q - shifted[PosW-1:0];
      quo_nx[k_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_CONTROL;
      count_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
      k_q     <= '0;
    end else begin
      if (cmd_i.take) begin
        kind_q  <= kind_nx;
        count_q <= count_nx;
      end
      if (cmd_i.prep) begin
        col_q <= col_n;
        row_q <= row_n;
      end else if (cmd_i.emit) begin
        if (done) begin
          col_q   <= '0;
          row_q   <= '0;
          kind_q  <= KIND_CONTROL;
          count_q <= '0;
        end
        k_q <= 3'(QuotW - 1);
      end else if (cmd_i.step) begin
        k_q <= k_q - 3'd1;
        if (k_q == '0) begin
          col_q <= rem_nx[DimW-1:0];
          row_q <= row_q + DimW'(quo_nx);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      run_q    <= run_nx;
      color_q  <= color_nx;
      transp_q <= transp_nx;
    end
    if (cmd_i.prep) prod_q <= ProdW'(rows_below) * ProdW'(cfg_i.width);
    if (cmd_i.emit) begin
      rem_q <= PosW'(col_q) + PosW'(len);
      quo_q <= '0;
    end else if (cmd_i.step) begin
      rem_q <= rem_nx;
      quo_q <= quo_nx;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      span_x_o      <= col_q;
      span_y_o      <= row_q;
      span_length_o <= len;
      color_index_o <= transp_q ? '0 : color_q;
      transparent_o <= transp_q;
      image_done_o  <= done;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.span     = span_nx;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.done     = done;
  assign status_o.div_last = (k_q == '0);

endmodule

// File: sim/palette_image_rle_decoder_tb.sv
// Testbench for the palette image span decoder: drives pixel-data bytes and APB register
// writes, predicts every span from its own model of the decoder and checks each output span.
// Depends on pird_pkg and the palette_image_rle_decoder top level.
module palette_image_rle_decoder_tb;
  import pird_pkg::*;

  localparam logic [1:0]  RegUnused    = 2'd3;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned RandomPhases = 12;
  localparam int unsigned PhaseItems   = 125;
  localparam int unsigned TimeoutTime  = 10_000_000;

  typedef struct packed {
    logic [DimW-1:0]  x;
    logic [DimW-1:0]  y;
    logic [RunW-1:0]  length;
    logic [ByteW-1:0] color;
    logic             transparent;
    logic             done;
  } span_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ByteW-1:0] data_byte_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [DimW-1:0]  span_x_o;
  logic [DimW-1:0]  span_y_o;
  logic [RunW-1:0]  span_length_o;
  logic [ByteW-1:0] color_index_o;
  logic             transparent_o;
  logic             image_done_o;

  // decoder model state
  logic [DimW-1:0]  cfg_width;
  logic [DimW-1:0]  cfg_height;
  logic             cfg_compressed;
  int unsigned      pos_col;
  int unsigned      pos_row;
  logic [RunW-1:0]  run_count;
  pird_kind_e       run_kind;

  span_t       expected_spans[$];
  int unsigned mismatch_count = 0;
  bit          gaps_on = 1'b1;
  int unsigned burst_left = 0;
  bit          hold_request = 1'b0;

  palette_image_rle_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .span_x_o      (span_x_o),
    .span_y_o      (span_y_o),
    .span_length_o (span_length_o),
    .color_index_o (color_index_o),
    .transparent_o (transparent_o),
    .image_done_o  (image_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic int unsigned effective_size(input logic [DimW-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  function automatic void place_span(input int unsigned run, input logic [ByteW-1:0] color,
                                     input bit transp);
    int unsigned w;
    int unsigned h;
    int unsigned remaining;
    int unsigned len;
    int unsigned pos;
    span_t s;
    w = effective_size(cfg_width);
    h = effective_size(cfg_height);
    // a size change can leave the position outside the image
    if (pos_col >= w || pos_row >= h) begin
      pos_col = 0;
      pos_row = 0;
    end
    remaining = (h - 1 - pos_row) * w + (w - pos_col);
    len = (run < remaining) ? run : remaining;
    s.x = pos_col[DimW-1:0];
    s.y = pos_row[DimW-1:0];
    s.length = len[RunW-1:0];
    s.color = transp ? '0 : color;
    s.transparent = transp;
    s.done = (len == remaining);
    expected_spans.push_back(s);
    if (s.done) begin
      // image end drops whatever run is still pending
      pos_col = 0;
      pos_row = 0;
      run_kind = KIND_CONTROL;
      run_count = '0;
    end else begin
      pos = pos_col + len;
      pos_row = pos_row + pos / w;
      pos_col = pos % w;
    end
  endfunction

  function automatic void predict_byte(input logic [ByteW-1:0] value);
    int unsigned run;
    case (run_kind)
      KIND_LITERAL: begin
        if (run_count == '0) run_kind = KIND_CONTROL;
        else run_count = run_count - RunW'(1);
        place_span(1, value, 1'b0);
      end
      KIND_REPEAT: begin
        run = 32'(run_count);
        run_kind = KIND_CONTROL;
        run_count = '0;
        if (run != 0) place_span(run, value, 1'b0);
      end
      default: begin
        run_kind = KIND_CONTROL;
        run_count = '0;
        if (cfg_compressed) begin
          if (value > SkipBase) begin
            place_span(32'(value - SkipBase), '0, 1'b1);
          end else if (value != '0) begin
            run_kind = KIND_LITERAL;
            run_count = RunW'(value - 8'd1);
          end
        end else if (value > RepeatBase) begin
          run_kind = KIND_REPEAT;
          run_count = RunW'(value - RepeatBase);
        end else begin
          place_span(1, value, 1'b0);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("mismatch: %s got %0d expected %0d", what, got, want);
  endtask

  task automatic check_span();
    span_t want;
    if (expected_spans.size() == 0) begin
      report_mismatch("span with none pending, span_x", 32'(span_x_o), 0);
      return;
    end
    want = expected_spans.pop_front();
    if (span_x_o !== want.x) report_mismatch("span_x", 32'(span_x_o), 32'(want.x));
    if (span_y_o !== want.y) report_mismatch("span_y", 32'(span_y_o), 32'(want.y));
    if (span_length_o !== want.length)
      report_mismatch("span_length", 32'(span_length_o), 32'(want.length));
    if (color_index_o !== want.color)
      report_mismatch("color_index", 32'(color_index_o), 32'(want.color));
    if (transparent_o !== want.transparent)
      report_mismatch("transparent", 32'(transparent_o), 32'(want.transparent));
    if (image_done_o !== want.done)
      report_mismatch("image_done", 32'(image_done_o), 32'(want.done));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) check_span();
  end

  // receiver: stall pattern is redrawn after a random stretch; long hold on request
  initial begin
    int unsigned mode;
    int unsigned stretch;
    int unsigned tick;
    mode = 0;
    stretch = 0;
    tick = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 3);
          stretch = $urandom_range(50, 300);
        end
        stretch--;
        tick++;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ((tick % 7) >= 3);
          default: out_ready_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(input logic [ByteW-1:0] value);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    data_byte_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    predict_byte(value);
  endtask

  // stop sending and wait until every span has come back and the block is quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_spans.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [DataW-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegWidth:  cfg_width = value[DimW-1:0];
      RegHeight: cfg_height = value[DimW-1:0];
      RegMode:   cfg_compressed = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // unused upper data bits carry random junk
  task automatic configure(input int unsigned w, input int unsigned h, input bit compressed);
    logic [DataW-1:0] junk;
    settle();
    junk = $urandom;
    apb_write(RegWidth, (junk & 32'hFFFF_F000) | (w & 32'hFFF));
    junk = $urandom;
    apb_write(RegHeight, (junk & 32'hFFFF_F000) | (h & 32'hFFF));
    junk = $urandom;
    apb_write(RegMode, (junk & ~32'h1) | DataW'(compressed));
  endtask

  function automatic int unsigned random_size();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 0;
    if (pick == 1) return 4095;
    if (pick == 2) return $urandom_range(1, 4095);
    return $urandom_range(1, 12);
  endfunction

  // ---------------------------------------------------------------- tests

  // 1x1 plain image out of reset
  task automatic test_reset_state();
    send_byte(8'h00);
    send_byte(8'hC0);
    send_byte(8'hC1);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h5A);
  endtask

  task automatic test_plain_coding();
    configure(7, 3, 1'b0);
    send_byte(8'h12);
    send_byte(8'hC3);
    send_byte(8'h34);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h80);
  endtask

  task automatic test_compressed_coding();
    configure(300, 2, 1'b1);
    send_byte(8'h00);
    send_byte(8'h81);
    send_byte(8'hFF);
    // count 128 announces the longest literal run
    send_byte(8'h80);
    for (int i = 0; i < 128; i++) send_byte(i[7:0] ^ 8'hA5);
    send_byte(8'h03);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
  endtask

  // literals still due at the image end are dropped
  task automatic test_image_end();
    configure(2, 2, 1'b1);
    send_byte(8'h10);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(8'h04);
    send_byte(8'h83);
    send_byte(8'h85);
  endtask

  // pending kind wins over a mode flipped mid-run
  task automatic test_mode_switch();
    configure(16, 4, 1'b0);
    send_byte(8'hC5);
    settle();
    apb_write(RegMode, 32'h1);
    send_byte(8'h44);
    send_byte(8'h03);
    settle();
    apb_write(RegMode, 32'h0);
    send_byte(8'hF0);
    send_byte(8'h00);
    send_byte(8'hC8);
    send_byte(8'hC8);
    send_byte(8'h11);
  endtask

  task automatic test_size_limits();
    configure(0, 0, 1'b1);
    send_byte(8'h81);
    send_byte(8'h05);
    send_byte(8'h77);
    send_byte(8'h90);
    settle();
    apb_write(RegUnused, 32'h5);
    send_byte(8'hFF);
    configure(4095, 1, 1'b1);
    repeat (33) send_byte(8'hFF);
    configure(1, 4095, 1'b1);
    repeat (33) send_byte(8'hFF);
  endtask

  // shrinking the image leaves the position outside it
  task automatic test_size_change();
    configure(10, 10, 1'b0);
    send_byte(8'hFF);
    send_byte(8'h01);
    configure(10, 3, 1'b0);
    send_byte(8'h22);
    configure(4, 3, 1'b0);
    send_byte(8'hC4);
    send_byte(8'h33);
    configure(1, 3, 1'b0);
    send_byte(8'h44);
  endtask

  // receiver holds off while bytes keep coming, so the input side has to stall
  task automatic test_backpressure();
    configure(64, 64, 1'b0);
    gaps_on = 1'b0;
    hold_request = 1'b1;
    repeat (48) send_byte(8'($urandom_range(0, 192)));
    settle();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_streams();
    int unsigned sent;
    int unsigned n;
    int unsigned pick;
    repeat (RandomPhases) begin
      configure(random_size(), random_size(), 1'($urandom_range(0, 1)));
      gaps_on = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      sent = 0;
      while (sent < PhaseItems) begin
        pick = $urandom_range(0, 9);
        if (cfg_compressed) begin
          if (pick < 6) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
            send_byte(n[7:0]);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            sent += n + 1;
          end else if (pick < 8) begin
            send_byte(8'($urandom_range(129, 255)));
            sent++;
          end else if (pick == 8) begin
            send_byte(8'h00);
          end else begin
            send_byte(8'($urandom_range(0, 255)));
            sent++;
          end
        end else begin
          if (pick < 5) begin
            send_byte(8'($urandom_range(0, 192)));
            sent++;
          end else if (pick < 8) begin
            send_byte(8'($urandom_range(193, 255)));
            send_byte(8'($urandom_range(0, 255)));
            sent += 2;
          end else begin
            send_byte(8'($urandom_range(0, 255)));
            sent++;
          end
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    cfg_width = 12'd1;
    cfg_height = 12'd1;
    cfg_compressed = 1'b0;
    pos_col = 0;
    pos_row = 0;
    run_count = '0;
    run_kind = KIND_CONTROL;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_plain_coding();
    test_compressed_coding();
    test_image_end();
    test_mode_switch();
    test_size_limits();
    test_size_change();
    test_backpressure();
    test_random_streams();
    settle();

    if (mismatch_count == 0 && expected_spans.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TimeoutTime);
    $display("Verification failed");
    $finish;
  end

endmodule
